// ===== rtl/core/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg - shared types and constants of the tilt complementary filter
// Field widths, command and status structs between controller and datapath,
// the arctangent table used by the cordic and a 32-bit saturation helper.
// ----------------------------------------------------------------------------
package tcf_pkg;

   // field widths
   localparam int DATA_W     = 32;
   localparam int RAW_W      = 16;
   localparam int TIME_W     = 32;
   localparam int STEP_W     = 16;
   localparam int WEIGHT_W   = 17;
   localparam int GAIN_W     = 24;
   localparam int FALLBACK_W = 10;
   localparam int MAX_STEP_W = 16;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLEND_WEIGHT  = 2'd0,
      CSR_RATE_GAIN     = 2'd1,
      CSR_FALLBACK_STEP = 2'd2,
      CSR_MAX_STEP      = 2'd3
   } csr_index_type;

   localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE       = 17'd65536;
   localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET     = 17'd64225;
   localparam logic [GAIN_W-1:0]     GAIN_RESET       = 24'd128070;
   localparam logic [FALLBACK_W-1:0] FALLBACK_RESET   = 10'd5;
   localparam logic [MAX_STEP_W-1:0] MAX_STEP_RESET   = 16'd1000;
   localparam int                    GAIN_FRAC        = 24;

   // shared multiplier
   localparam int MUL_A_W = 40;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // blend rounding from Q1.16 weight
   localparam int                       BLEND_SHIFT = 16;
   localparam logic signed [PROD_W-1:0] BLEND_HALF  = PROD_W'(32768);

   // cordic
   localparam int CORDIC_W    = 36;
   localparam int IN_SCALE_SH = 16;
   localparam int ANG_W       = 34;
   localparam int ANG_FRAC    = 24;
   localparam int ATAN_W      = 30;
   localparam int TAB_LEN     = 24;
   localparam int TAB_IDX_W   = 5;
   localparam logic signed [ANG_W-1:0] DEG180_Q24 = 34'sd3019898880;

   // divide by one thousand, two quotient bits a step
   localparam int DIV_W     = 50;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DIV_CNT_W = 5;
   localparam int REM_W     = 10;
   localparam int DIVISOR   = 1000;
   localparam logic [DIV_W-1:0] DIV_BIAS = DIV_W'(DIVISOR / 2);
   localparam logic [DIV_W-1:0] DIV_CEIL = DIV_W'(DIVISOR - 1);

   typedef enum logic [2:0] {
      MUL_RATE_X,
      MUL_RATE_Z,
      MUL_STEP,
      MUL_GYRO_PATH,
      MUL_ACC_PATH
   } mul_op_type;

   typedef enum logic [2:0] {
      POST_NONE,
      POST_RATE_X,
      POST_RATE_Z,
      POST_STEP,
      POST_GYRO_PATH,
      POST_ACC_PATH
   } post_op_type;

   typedef struct packed {
      logic        capture;
      mul_op_type  mul_op;
      post_op_type post_op;
      logic        div_start;
      logic        form_g;
      logic        round_pitch;
      logic        out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic div_done;
   } ctrl_status_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic [ATAN_W-1:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:    val = 30'd754974720;
         5'd1:    val = 30'd445687602;
         5'd2:    val = 30'd235489088;
         5'd3:    val = 30'd119537938;
         5'd4:    val = 30'd60000934;
         5'd5:    val = 30'd30029717;
         5'd6:    val = 30'd15018523;
         5'd7:    val = 30'd7509720;
         5'd8:    val = 30'd3754917;
         5'd9:    val = 30'd1877466;
         5'd10:   val = 30'd938734;
         5'd11:   val = 30'd469367;
         5'd12:   val = 30'd234684;
         5'd13:   val = 30'd117342;
         5'd14:   val = 30'd58671;
         5'd15:   val = 30'd29335;
         5'd16:   val = 30'd14668;
         5'd17:   val = 30'd7334;
         5'd18:   val = 30'd3667;
         5'd19:   val = 30'd1833;
         5'd20:   val = 30'd917;
         5'd21:   val = 30'd458;
         5'd22:   val = 30'd229;
         5'd23:   val = 30'd115;
         default: val = '0;
      endcase
      return val;
   endfunction

   // clamp a wide signed value into 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] res;
      if ((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1])) begin
         res = v[DATA_W-1:0];
      end else if (v[PROD_W-1]) begin
         res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/tcf_cordic.sv =====
// ----------------------------------------------------------------------------
// tcf_cordic - iterative vectoring cordic for atan2 in degrees
// One micro-rotation per cycle; angle out has 24 fraction bits.
// ----------------------------------------------------------------------------
module tcf_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tcf_pkg::RAW_W-1:0]  acc_y,
   input  logic signed [tcf_pkg::RAW_W-1:0]  acc_z,
   output logic signed [tcf_pkg::ANG_W-1:0]  angle,
   output logic                              done
);
   import tcf_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
   localparam logic [TAB_IDX_W-1:0] LAST_IDX = TAB_IDX_W'(NSTEPS - 1);

   logic signed [CORDIC_W-1:0]  x_ff, y_ff;
   logic signed [ANG_W-1:0]     z_ff;
   logic [TAB_IDX_W-1:0]        idx_ff;
   logic                        busy_ff, done_ff;

   logic signed [CORDIC_W-1:0]  y_sc, z_sc, dx, dy;
   logic signed [ANG_W-1:0]     step_ang;

   // inputs scaled by 2^16
   assign y_sc = $signed({{(CORDIC_W-RAW_W-IN_SCALE_SH){acc_y[RAW_W-1]}}, acc_y,
                          {IN_SCALE_SH{1'b0}}});
   assign z_sc = $signed({{(CORDIC_W-RAW_W-IN_SCALE_SH){acc_z[RAW_W-1]}}, acc_z,
                          {IN_SCALE_SH{1'b0}}});

   assign dx       = y_ff >>> idx_ff;
   assign dy       = x_ff >>> idx_ff;
   assign step_ang = ANG_W'(atan_q24(idx_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (start) begin
         idx_ff <= '0;
         if (acc_y == '0) begin
            // on the x axis: no rotation needed
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
         end
      end else if (busy_ff) begin
         idx_ff <= idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         if (acc_y == '0) begin
            z_ff <= (acc_z < 0) ? DEG180_Q24 : '0;
         end else if (acc_z < 0) begin
            // left half plane: pre-rotate by half a turn
            z_ff <= (acc_y > 0) ? DEG180_Q24 : -DEG180_Q24;
            x_ff <= -z_sc;
            y_ff <= -y_sc;
         end else begin
            z_ff <= '0;
            x_ff <= z_sc;
            y_ff <= y_sc;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + step_ang;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - step_ang;
         end
      end
   end

   assign angle = z_ff;
   assign done  = done_ff;

endmodule

// ===== rtl/core/tcf_div1k.sv =====
// ----------------------------------------------------------------------------
// tcf_div1k - unsigned divide by one thousand
// Radix-4 restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tcf_div1k (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tcf_pkg::DIV_W-1:0]   dividend,
   output logic [tcf_pkg::DIV_W-1:0]   quotient,
   output logic                        done
);
   import tcf_pkg::*;

   localparam logic [REM_W+1:0] DIV_X1 = (REM_W+2)'(DIVISOR);
   localparam logic [REM_W+1:0] DIV_X2 = (REM_W+2)'(2 * DIVISOR);
   localparam logic [REM_W+1:0] DIV_X3 = (REM_W+2)'(3 * DIVISOR);
   localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIV_STEPS - 1);

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvd_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [REM_W+1:0]     part;
   logic [1:0]           digit;

   // quotient bits shift in from the bottom as dividend bits leave the top
   assign part = {rem_ff, dvd_ff[DIV_W-1 -: 2]};

   always_comb begin
      if (part >= DIV_X3) begin
         digit  = 2'd3;
         rem_in = REM_W'(part - DIV_X3);
      end else if (part >= DIV_X2) begin
         digit  = 2'd2;
         rem_in = REM_W'(part - DIV_X2);
      end else if (part >= DIV_X1) begin
         digit  = 2'd1;
         rem_in = REM_W'(part - DIV_X1);
      end else begin
         digit  = 2'd0;
         rem_in = REM_W'(part);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST_CNT) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[DIV_W-3:0], digit};
      end
   end

   assign quotient = dvd_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/core/tcf_dpath.sv =====
// ----------------------------------------------------------------------------
// tcf_dpath - datapath of the tilt complementary filter
// Config registers, step time, shared multiplier, cordic, divider, blend
// and the result registers.
// ----------------------------------------------------------------------------
module tcf_dpath #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [tcf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]         csr_data,
   input  logic signed [tcf_pkg::RAW_W-1:0]       req_acc_y_raw,
   input  logic signed [tcf_pkg::RAW_W-1:0]       req_acc_z_raw,
   input  logic signed [tcf_pkg::RAW_W-1:0]       req_rate_x_raw,
   input  logic signed [tcf_pkg::RAW_W-1:0]       req_rate_z_raw,
   input  logic [tcf_pkg::TIME_W-1:0]             req_time_ms,
   input  tcf_pkg::ctrl_cmd_type                  cmd,
   output tcf_pkg::ctrl_status_type               status,
   output logic signed [tcf_pkg::DATA_W-1:0]      rsp_pitch_deg,
   output logic signed [tcf_pkg::DATA_W-1:0]      rsp_pitch_speed_dps,
   output logic signed [tcf_pkg::DATA_W-1:0]      rsp_yaw_speed_dps,
   output logic [tcf_pkg::STEP_W-1:0]             rsp_step_ms
);
   import tcf_pkg::*;

   localparam int RATE_SHIFT = GAIN_FRAC - FRAC_BITS;
   localparam int ANG_SHIFT  = ANG_FRAC - FRAC_BITS;
   localparam logic signed [PROD_W-1:0] RATE_HALF = PROD_W'((2 ** RATE_SHIFT) / 2);
   localparam logic signed [ANG_W-1:0]  ANG_HALF  = ANG_W'((2 ** ANG_SHIFT) / 2);

   // config and filter state
   logic [WEIGHT_W-1:0]      alpha_ff, beta_ff, alpha_in;
   logic [GAIN_W-1:0]        gain_ff;
   logic [FALLBACK_W-1:0]    fallback_ff;
   logic [MAX_STEP_W-1:0]    max_step_ff;
   logic [TIME_W-1:0]        prev_time_ff;
   logic signed [DATA_W-1:0] fused_ff;

   // working registers
   logic signed [RAW_W-1:0]   gx_ff, gz_ff;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [PROD_W-1:0]  prod_ff, blend_ff;
   logic signed [DATA_W-1:0]  rate_x_ff, rate_z_ff;
   logic [DIV_W-1:0]          n_ff;
   logic signed [MUL_A_W-1:0] g_ff, g_in;
   logic signed [ANG_W-1:0]   accp_ff;

   // result registers
   logic signed [DATA_W-1:0]  out_pitch_ff, out_rate_x_ff, out_rate_z_ff;
   logic [STEP_W-1:0]         out_step_ff;

   logic [TIME_W-1:0]         diff;
   logic signed [MUL_A_W-1:0] mul_a, fused_ext, q_low;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  rate_rnd, pitch_rnd;
   logic [DIV_W-1:0]          div_mag, quotient;
   logic signed [ANG_W-1:0]   cordic_angle;
   logic                      cordic_done, div_done;

   // weight above one counts as one
   assign alpha_in = (csr_data[WEIGHT_W-1:0] > WEIGHT_ONE) ? WEIGHT_ONE
                                                          : csr_data[WEIGHT_W-1:0];

   // measured interval, fallback when zero or too long
   assign diff    = req_time_ms - prev_time_ff;
   assign step_in = ((diff == '0) || (diff > TIME_W'(max_step_ff)))
                    ? STEP_W'(fallback_ff) : diff[STEP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= WEIGHT_RESET;
         beta_ff      <= WEIGHT_ONE - WEIGHT_RESET;
         gain_ff      <= GAIN_RESET;
         fallback_ff  <= FALLBACK_RESET;
         max_step_ff  <= MAX_STEP_RESET;
         prev_time_ff <= '0;
         fused_ff     <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_BLEND_WEIGHT: begin
                  alpha_ff <= alpha_in;
                  beta_ff  <= WEIGHT_ONE - alpha_in;
               end
               CSR_RATE_GAIN:     gain_ff     <= csr_data[GAIN_W-1:0];
               CSR_FALLBACK_STEP: fallback_ff <= csr_data[FALLBACK_W-1:0];
               CSR_MAX_STEP:      max_step_ff <= csr_data[MAX_STEP_W-1:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            prev_time_ff <= req_time_ms;
         end
         if (cmd.round_pitch) begin
            fused_ff <= sat32(pitch_rnd);
         end
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_op)
         MUL_RATE_X: begin
            mul_a = MUL_A_W'(gx_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         MUL_RATE_Z: begin
            mul_a = MUL_A_W'(gz_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         MUL_STEP: begin
            mul_a = MUL_A_W'(rate_x_ff);
            mul_b = $signed(MUL_B_W'(step_ff));
         end
         MUL_GYRO_PATH: begin
            mul_a = g_ff;
            mul_b = $signed(MUL_B_W'(alpha_ff));
         end
         MUL_ACC_PATH: begin
            mul_a = MUL_A_W'(accp_ff);
            mul_b = $signed(MUL_B_W'(beta_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign rate_rnd  = (prod_ff + RATE_HALF) >>> RATE_SHIFT;
   assign pitch_rnd = (blend_ff + BLEND_HALF) >>> BLEND_SHIFT;

   // floor division of a negative value: divide (999 - n) and negate
   assign div_mag   = n_ff[DIV_W-1] ? (DIV_CEIL - n_ff) : n_ff;
   assign fused_ext = MUL_A_W'(fused_ff);
   assign q_low     = $signed(quotient[MUL_A_W-1:0]);
   assign g_in      = n_ff[DIV_W-1] ? (fused_ext - q_low) : (fused_ext + q_low);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.capture) begin
         gx_ff   <= req_rate_x_raw;
         gz_ff   <= req_rate_z_raw;
         step_ff <= step_in;
      end
      case (cmd.post_op)
         POST_RATE_X:    rate_x_ff <= sat32(rate_rnd);
         POST_RATE_Z:    rate_z_ff <= sat32(rate_rnd);
         POST_STEP:      n_ff      <= prod_ff[DIV_W-1:0] + DIV_BIAS;
         POST_GYRO_PATH: blend_ff  <= prod_ff;
         POST_ACC_PATH:  blend_ff  <= blend_ff + prod_ff;
         default: ;
      endcase
      if (cmd.form_g) begin
         g_ff    <= g_in;
         accp_ff <= (cordic_angle + ANG_HALF) >>> ANG_SHIFT;
      end
      if (cmd.out_load) begin
         out_pitch_ff  <= fused_ff;
         out_rate_x_ff <= rate_x_ff;
         out_rate_z_ff <= rate_z_ff;
         out_step_ff   <= step_ff;
      end
   end

   tcf_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.capture),
      .acc_y  (req_acc_y_raw),
      .acc_z  (req_acc_z_raw),
      .angle  (cordic_angle),
      .done   (cordic_done)
   );

   tcf_div1k u_div1k (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_mag),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.cordic_done = cordic_done;
   assign status.div_done    = div_done;

   assign rsp_pitch_deg       = out_pitch_ff;
   assign rsp_pitch_speed_dps = out_rate_x_ff;
   assign rsp_yaw_speed_dps   = out_rate_z_ff;
   assign rsp_step_ms         = out_step_ff;

endmodule

// ===== rtl/core/tcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcf_ctrl - sequencer of the tilt complementary filter
// Walks one item through the multiplier slots, divider and blend, and owns
// the handshake flags of both channels.
// ----------------------------------------------------------------------------
module tcf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  tcf_pkg::ctrl_status_type   status,
   output tcf_pkg::ctrl_cmd_type      cmd
);
   import tcf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RATE_X,
      S_RATE_Z,
      S_STEP,
      S_DIV_GO,
      S_DIV_START,
      S_WAIT,
      S_FORM,
      S_GYRO,
      S_ACC,
      S_SUM,
      S_ROUND,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      cmd.mul_op   = MUL_RATE_X;
      cmd.post_op  = POST_NONE;
      state_in     = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_RATE_X;
            end
         end
         S_RATE_X: begin
            cmd.mul_op = MUL_RATE_X;
            state_in   = S_RATE_Z;
         end
         S_RATE_Z: begin
            cmd.mul_op  = MUL_RATE_Z;
            cmd.post_op = POST_RATE_X;
            state_in    = S_STEP;
         end
         S_STEP: begin
            cmd.mul_op  = MUL_STEP;
            cmd.post_op = POST_RATE_Z;
            state_in    = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.post_op = POST_STEP;
            state_in    = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (status.div_done && status.cordic_done) begin
               state_in = S_FORM;
            end
         end
         S_FORM: begin
            cmd.form_g = 1'b1;
            state_in   = S_GYRO;
         end
         S_GYRO: begin
            cmd.mul_op = MUL_GYRO_PATH;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.mul_op  = MUL_ACC_PATH;
            cmd.post_op = POST_GYRO_PATH;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.post_op = POST_ACC_PATH;
            state_in    = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_pitch = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            cmd.out_load = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/tilt_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter - pitch estimate from one raw imu sample per item
// Accel pitch by cordic atan2, gyro rates by reciprocal gain, wrapped step
// time with fallback, then pitch = a*(pitch + rate*dt) + (1-a)*accel_pitch.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | content
//  ---------+-----------+-----------------------+-------------------------------
//  csr_     | in        | csr_valid / csr_ready | register index and write data
//  req_     | in        | req_valid / req_ready | accel y/z, gyro x/z, timestamp
//  rsp_     | out       | rsp_valid / rsp_ready | pitch, pitch rate, yaw rate, step
//
//  an item passes the rate, step, divide, wait, blend and round states from
//  accept to rsp_valid, one item in flight at a time; that path is governed
//  by the radix-4 divide by one thousand (25 steps) that scales rate*step;
//  the cordic runs beside it and is never the longer path
//  a result waits in its own register, so the next item is taken while it
//  waits; only the final load stalls when the previous result is still held
//  synchronous active-high reset: registers back to their reset values,
//  pitch and previous timestamp cleared, no result pending
//  csr_ready is always high; write registers only while no item is in flight
//
module tilt_complementary_filter #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]      csr_data,
   // sample items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tcf_pkg::RAW_W-1:0]    req_acc_y_raw,
   input  logic signed [tcf_pkg::RAW_W-1:0]    req_acc_z_raw,
   input  logic signed [tcf_pkg::RAW_W-1:0]    req_rate_x_raw,
   input  logic signed [tcf_pkg::RAW_W-1:0]    req_rate_z_raw,
   input  logic [tcf_pkg::TIME_W-1:0]          req_time_ms,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tcf_pkg::DATA_W-1:0]   rsp_pitch_deg,
   output logic signed [tcf_pkg::DATA_W-1:0]   rsp_pitch_speed_dps,
   output logic signed [tcf_pkg::DATA_W-1:0]   rsp_yaw_speed_dps,
   output logic [tcf_pkg::STEP_W-1:0]          rsp_step_ms
);
   import tcf_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            csr_write;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sequencer: handshake flags and one command set per cycle
   tcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, filter state and result registers
   tcf_dpath #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_acc_y_raw       (req_acc_y_raw),
      .req_acc_z_raw       (req_acc_z_raw),
      .req_rate_x_raw      (req_rate_x_raw),
      .req_rate_z_raw      (req_rate_z_raw),
      .req_time_ms         (req_time_ms),
      .cmd                 (cmd),
      .status              (status),
      .rsp_pitch_deg       (rsp_pitch_deg),
      .rsp_pitch_speed_dps (rsp_pitch_speed_dps),
      .rsp_yaw_speed_dps   (rsp_yaw_speed_dps),
      .rsp_step_ms         (rsp_step_ms)
   );

endmodule

// ===== rtl/core/tcf_checker.sv =====
// ----------------------------------------------------------------------------
// tcf_checker - port-level checks of the tilt complementary filter
// Watches handshakes and result timing, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tcf_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [tcf_pkg::DATA_W-1:0]   rsp_pitch_deg,
   input  logic signed [tcf_pkg::DATA_W-1:0]   rsp_pitch_speed_dps,
   input  logic signed [tcf_pkg::DATA_W-1:0]   rsp_yaw_speed_dps,
   input  logic [tcf_pkg::STEP_W-1:0]          rsp_step_ms
);

   // reset leaves no result pending and the input open
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("reset did not clear the result or open the input");

   // one item at a time: the input closes after each accept
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open right after an accept");

   // a new result is only loaded from the final sequencer step, so the input was closed before it rises
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without work in progress");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pitch_deg)
         && $stable(rsp_pitch_speed_dps) && $stable(rsp_yaw_speed_dps)
         && $stable(rsp_step_ms)))
      else $error("stalled result changed or dropped");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (.*);
